>>> rtl/core/bdel_pkg.sv
package bdel_pkg;

    localparam int unsigned NUM_BTN     = 2;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_WINDOW  = 8'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd50;
    localparam logic [CFG_W-1:0] EVENT_WINDOW_RST  = 16'd250;

    // What one lane sees of an accepted request.
    typedef struct packed {
        logic              en;
        logic [TIME_W-1:0] now_ms;
        logic              do_update;
        logic              raw;
        logic              clear_press;
        logic              clear_release;
    } lane_req_t;

    // What one lane reports for that request.
    typedef struct packed {
        logic              level;
        logic              fresh_press;
        logic              fresh_release;
        logic [TIME_W-1:0] held_time;
    } lane_res_t;

endpackage

>>> rtl/core/bdel_lane.sv
module bdel_lane
    import bdel_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_req_t        req,
    input  logic [CFG_W-1:0] debounce_time,
    input  logic [CFG_W-1:0] event_window,
    output lane_res_t        res
);

    logic              raw_level_reg, raw_level_next;
    logic              deb_level_reg, deb_level_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;
    logic              press_lat_reg, press_lat_next;
    logic              release_lat_reg, release_lat_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [TIME_W-1:0] release_time_reg, release_time_next;

    logic              raw_chg;
    logic              stable;
    logic              rise;
    logic              fall;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] press_age;
    logic [TIME_W-1:0] release_age;
    logic              press_lat_mid;
    logic              release_lat_mid;
    logic              press_fresh_age;
    logic              release_fresh_age;

    always_comb
    begin
        raw_chg      = req.do_update && (req.raw != raw_level_reg);
        since_change = req.now_ms - last_change_reg;
        // A change in this very request restarts the count from zero.
        if (raw_chg)
        begin
            stable = (debounce_time == '0);
        end
        else
        begin
            stable = (since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
        end

        raw_level_next   = req.do_update ? req.raw : raw_level_reg;
        last_change_next = raw_chg ? req.now_ms : last_change_reg;
        deb_level_next   = (req.do_update && stable) ? raw_level_next : deb_level_reg;

        rise = deb_level_next && !deb_level_reg;
        fall = !deb_level_next && deb_level_reg;

        // An event latched in this request has age zero.
        press_age   = rise ? '0 : (req.now_ms - press_time_reg);
        release_age = fall ? '0 : (req.now_ms - release_time_reg);

        press_fresh_age   = (press_age <= {{(TIME_W-CFG_W){1'b0}}, event_window});
        release_fresh_age = (release_age <= {{(TIME_W-CFG_W){1'b0}}, event_window});

        press_lat_mid   = rise || press_lat_reg;
        release_lat_mid = fall || release_lat_reg;

        press_lat_next    = press_lat_mid && !req.clear_press;
        release_lat_next  = release_lat_mid && !req.clear_release;
        press_time_next   = rise ? req.now_ms : press_time_reg;
        release_time_next = fall ? req.now_ms : release_time_reg;

        res.level         = deb_level_next;
        res.fresh_press   = req.clear_press && press_lat_mid && press_fresh_age;
        res.fresh_release = req.clear_release && release_lat_mid && release_fresh_age;
        res.held_time     = deb_level_next ? press_age : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg    <= 1'b0;
            deb_level_reg    <= 1'b0;
            last_change_reg  <= '0;
            press_lat_reg    <= 1'b0;
            release_lat_reg  <= 1'b0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
        end
        else if (req.en)
        begin
            raw_level_reg    <= raw_level_next;
            deb_level_reg    <= deb_level_next;
            last_change_reg  <= last_change_next;
            press_lat_reg    <= press_lat_next;
            release_lat_reg  <= release_lat_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
        end
    end

endmodule

>>> rtl/core/bdel_merge.sv
module bdel_merge
    import bdel_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 held_select,
    input  lane_res_t            lane_res [NUM_BTN],
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [M_TDATA_W-1:0] merged;
    logic [NUM_BTN-1:0]   levels;
    logic [NUM_BTN-1:0]   fresh_p;
    logic [NUM_BTN-1:0]   fresh_r;
    logic [TIME_W-1:0]    held;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;

    always_comb
    begin
        for (int i = 0; i < NUM_BTN; i++)
        begin
            levels[i]  = lane_res[i].level;
            fresh_p[i] = lane_res[i].fresh_press;
            fresh_r[i] = lane_res[i].fresh_release;
        end
        held   = lane_res[held_select].held_time;
        merged = {{(M_TDATA_W-TIME_W-3*NUM_BTN){1'b0}}, held, fresh_r, fresh_p, levels};
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = merged;
            end
        end
        else if (in_valid)
        begin
            // Output is stalled: park the new result in the skid stage.
            skid_valid_next = 1'b1;
            skid_data_next  = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/button_debounce_event_latch_top.sv
// Debouncer for two buttons with latched press and release events.
// Slave channel: one request per sample, carrying the millisecond time, the
// raw button levels and the masks of events to consume; do_update and
// held_select ride in s_tuser. Master channel: one result per request with
// the debounced levels, the consumed fresh events and the held time of the
// selected button.
// Each button has its own lane holding its state; all lanes work on the same
// request at once and a merge stage packs their results.
// Each result is registered in the merge output register, or in the skid stage
// when it stalls. Throughput is one request per clock while s_tready is high.
// The output register is backed by a one-entry skid stage, so a request is
// still taken while a result waits; s_tready drops only once both hold a
// result, and rises again the cycle after the receiver takes one.
// The config channel is always ready; index 0 writes debounce_time and index
// 1 writes event_window, other indexes are ignored. Write it only while idle.
// Reset clears all button state, drops both valids and loads the register
// defaults of 50 ms and 250 ms.
module button_debounce_event_latch_top
    import bdel_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] now_ms, [33:32] raw_pressed, [35:34] clear_press,
    // [37:36] clear_release, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] do_update, [1] held_select
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] pressed_levels, [3:2] fresh_press, [5:4] fresh_release,
    // [37:6] held_time, [39:38] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] debounce_time_reg;
    logic [CFG_W-1:0] event_window_reg;

    logic               accept;
    logic               merge_ready;
    logic [TIME_W-1:0]  now_ms;
    logic [NUM_BTN-1:0] raw_pressed;
    logic [NUM_BTN-1:0] clear_press;
    logic [NUM_BTN-1:0] clear_release;
    lane_req_t          lane_req [NUM_BTN];
    lane_res_t          lane_res [NUM_BTN];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg <= DEBOUNCE_TIME_RST;
            event_window_reg  <= EVENT_WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data;
                REG_EVENT_WINDOW:  event_window_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign s_tready      = merge_ready;
    assign accept        = s_tvalid && merge_ready;
    assign now_ms        = s_tdata[TIME_W-1:0];
    assign raw_pressed   = s_tdata[TIME_W +: NUM_BTN];
    assign clear_press   = s_tdata[TIME_W+NUM_BTN +: NUM_BTN];
    assign clear_release = s_tdata[TIME_W+2*NUM_BTN +: NUM_BTN];

    for (genvar i = 0; i < NUM_BTN; i++)
    begin : g_lane
        assign lane_req[i].en            = accept;
        assign lane_req[i].now_ms        = now_ms;
        assign lane_req[i].do_update     = s_tuser[0];
        assign lane_req[i].raw           = raw_pressed[i];
        assign lane_req[i].clear_press   = clear_press[i];
        assign lane_req[i].clear_release = clear_release[i];

        bdel_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .req           (lane_req[i]),
            .debounce_time (debounce_time_reg),
            .event_window  (event_window_reg),
            .res           (lane_res[i])
        );
    end

    bdel_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .held_select (s_tuser[1]),
        .lane_res    (lane_res),
        .in_ready    (merge_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // A stalled result plus a new request fills the skid stage; no request
    // may then be taken until the receiver frees a slot.
    a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && accept |=> !s_tready)
        else $error("request taken with result and skid stage both full");

    // A nonzero held time only comes from a button that is pressed.
    a_held_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[37:6] != '0) |-> (m_tdata[1:0] != '0))
        else $error("held time reported with no button pressed");

    // Every accepted request is followed by m_tvalid high in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

>>> test/tb_button_debounce_event_latch_top.sv
module tb_button_debounce_event_latch_top;
    import bdel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned PHASE_SAMPLES   = 205;
    localparam int unsigned DRAIN_CYCLES    = 8;
    // An index outside the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               do_update;
        logic [NUM_BTN-1:0] raw;
        logic [NUM_BTN-1:0] clear_press;
        logic [NUM_BTN-1:0] clear_release;
        logic               held_sel;
    } sample_t;

    typedef struct packed {
        logic [NUM_BTN-1:0] levels;
        logic [NUM_BTN-1:0] fresh_press;
        logic [NUM_BTN-1:0] fresh_release;
        logic [TIME_W-1:0]  held;
    } result_t;

    class debounce_tracker;
        bit [CFG_W-1:0]  debounce_ms;
        bit [CFG_W-1:0]  window_ms;
        bit              raw_lvl      [NUM_BTN];
        bit              stable_lvl   [NUM_BTN];
        bit [TIME_W-1:0] last_change  [NUM_BTN];
        bit              press_flag   [NUM_BTN];
        bit              release_flag [NUM_BTN];
        bit [TIME_W-1:0] press_at     [NUM_BTN];
        bit [TIME_W-1:0] release_at   [NUM_BTN];
        result_t         pending_results[$];
        int unsigned     mismatches;
        int unsigned     checked;

        function new();
            debounce_ms = DEBOUNCE_TIME_RST;
            window_ms   = EVENT_WINDOW_RST;
            foreach (raw_lvl[i])
            begin
                raw_lvl[i]      = 1'b0;
                stable_lvl[i]   = 1'b0;
                last_change[i]  = '0;
                press_flag[i]   = 1'b0;
                release_flag[i] = 1'b0;
                press_at[i]     = '0;
                release_at[i]   = '0;
            end
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_DEBOUNCE_TIME)
                debounce_ms = val;
            else if (idx == REG_EVENT_WINDOW)
                window_ms = val;
        endfunction

        function void note_sample(sample_t s);
            result_t         r;
            bit              nxt;
            bit [TIME_W-1:0] age;
            r = '0;
            for (int i = 0; i < NUM_BTN; i++)
            begin
                if (s.do_update)
                begin
                    nxt = stable_lvl[i];
                    if (s.raw[i] != raw_lvl[i])
                    begin
                        raw_lvl[i]     = s.raw[i];
                        last_change[i] = s.now_ms;
                    end
                    age = s.now_ms - last_change[i];
                    if (age >= debounce_ms)
                        nxt = raw_lvl[i];
                    if (nxt && !stable_lvl[i])
                    begin
                        press_flag[i] = 1'b1;
                        press_at[i]   = s.now_ms;
                    end
                    if (!nxt && stable_lvl[i])
                    begin
                        release_flag[i] = 1'b1;
                        release_at[i]   = s.now_ms;
                    end
                    stable_lvl[i] = nxt;
                end
                // A stale event is still consumed, it just reports 0.
                if (s.clear_press[i] && press_flag[i])
                begin
                    press_flag[i] = 1'b0;
                    age = s.now_ms - press_at[i];
                    if (age <= window_ms)
                        r.fresh_press[i] = 1'b1;
                end
                if (s.clear_release[i] && release_flag[i])
                begin
                    release_flag[i] = 1'b0;
                    age = s.now_ms - release_at[i];
                    if (age <= window_ms)
                        r.fresh_release[i] = 1'b1;
                end
                r.levels[i] = stable_lvl[i];
            end
            if (stable_lvl[s.held_sel])
                r.held = s.now_ms - press_at[s.held_sel];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got.levels        = word[1:0];
            got.fresh_press   = word[3:2];
            got.fresh_release = word[5:4];
            got.held          = word[37:6];
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding: %h", $realtime, word);
                return;
            end
            want = pending_results.pop_front();
            if (got.levels !== want.levels || got.fresh_press !== want.fresh_press ||
                got.fresh_release !== want.fresh_release || got.held !== want.held)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch levels %b/%b press %b/%b release %b/%b held %h/%h",
                             $realtime, got.levels, want.levels, got.fresh_press,
                             want.fresh_press, got.fresh_release, want.fresh_release,
                             got.held, want.held);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    debounce_tracker      sb;
    int unsigned          idle_cycles;
    int unsigned          tx_gap_pct;
    int unsigned          rx_stall_pct;
    int unsigned          n_sent;
    logic [TIME_W-1:0]    ms_clock;
    logic [NUM_BTN-1:0]   btn_level;
    logic [CFG_W-1:0]     db_plan  [NUM_PHASES];
    logic [CFG_W-1:0]     win_plan [NUM_PHASES];

    button_debounce_event_latch_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: takes results and stalls in random bursts.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall_left > 0)
                stall_left--;
            else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
                stall_left = $urandom_range(1, 19);
            m_tready <= (stall_left == 0);
        end
    end

    function automatic sample_t mk(logic [TIME_W-1:0] t, logic u, logic [NUM_BTN-1:0] r,
                                   logic [NUM_BTN-1:0] cp, logic [NUM_BTN-1:0] cr,
                                   logic sel);
        sample_t s;
        s.now_ms        = t;
        s.do_update     = u;
        s.raw           = r;
        s.clear_press   = cp;
        s.clear_release = cr;
        s.held_sel      = sel;
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, s.clear_release, s.clear_press, s.raw, s.now_ms};
        s_tuser  <= {s.held_sel, s.do_update};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(s);
        n_sent++;
    endtask

    task automatic sender_gap();
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no extra edge.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] win,
                                input bit poke_spare);
        cfg_write(REG_DEBOUNCE_TIME, db);
        cfg_write(REG_EVENT_WINDOW, win);
        if (poke_spare)
            cfg_write(REG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input logic [CFG_W-1:0] db,
                              input logic [CFG_W-1:0] win);
        int unsigned scale;
        int unsigned roll;
        sample_t     s;
        for (int unsigned k = 0; k < count; k++)
        begin
            // Time steps are sized to whichever threshold is picked, so both
            // sides of the debounce and freshness compares get hit.
            scale = $urandom_range(0, 1) ? db : win;
            roll  = $urandom_range(0, 99);
            if (roll < 2)
                ms_clock = $urandom();
            else if (roll < 3)
                ms_clock = 32'hFFFF_FFFF - $urandom_range(0, scale);
            else if (roll >= 12)
                ms_clock = ms_clock + $urandom_range(0, scale + scale / 4 + 3);
            for (int i = 0; i < NUM_BTN; i++)
                if ($urandom_range(0, 4) == 0)
                    btn_level[i] = !btn_level[i];
            s.now_ms        = ms_clock;
            s.raw           = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : btn_level;
            s.do_update     = ($urandom_range(0, 9) != 0);
            s.clear_press   = $urandom_range(0, 1) ? 2'($urandom_range(1, 3)) : 2'b00;
            s.clear_release = $urandom_range(0, 1) ? 2'($urandom_range(1, 3)) : 2'b00;
            s.held_sel      = 1'($urandom_range(0, 1));
            send_sample(s);
            if ($urandom_range(0, 79) == 0)
                wait_drained();
            else
                sender_gap();
        end
    endtask

    initial
    begin
        sb           = new();
        n_sent       = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        ms_clock     = '0;
        btn_level    = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset register values.
        send_sample(mk(32'd0,   1'b1, 2'b00, 2'b11, 2'b11, 1'b0));
        send_sample(mk(32'd10,  1'b1, 2'b11, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'd30,  1'b1, 2'b01, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'd60,  1'b1, 2'b01, 2'b00, 2'b00, 1'b0));
        // Without an update the raw bits are ignored.
        send_sample(mk(32'd70,  1'b0, 2'b10, 2'b00, 2'b00, 1'b0));
        send_sample(mk(32'd100, 1'b1, 2'b01, 2'b01, 2'b00, 1'b0));
        send_sample(mk(32'd100, 1'b1, 2'b01, 2'b01, 2'b00, 1'b0));
        send_sample(mk(32'd120, 1'b1, 2'b00, 2'b00, 2'b00, 1'b0));
        send_sample(mk(32'd170, 1'b1, 2'b00, 2'b00, 2'b10, 1'b0));
        send_sample(mk(32'd500, 1'b0, 2'b00, 2'b00, 2'b01, 1'b0));
        send_sample(mk(32'd510, 1'b1, 2'b11, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'd560, 1'b1, 2'b11, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'd600, 1'b1, 2'b00, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'd650, 1'b1, 2'b00, 2'b00, 2'b00, 1'b0));
        // Stale press and a release exactly at the window edge, in one request.
        send_sample(mk(32'd900, 1'b0, 2'b00, 2'b11, 2'b11, 1'b0));
        // The debounce interval spans the time wrap.
        send_sample(mk(32'hFFFF_FFFF, 1'b1, 2'b10, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'h0000_0031, 1'b1, 2'b10, 2'b00, 2'b00, 1'b1));
        send_sample(mk(32'h0000_0040, 1'b0, 2'b10, 2'b10, 2'b00, 1'b1));
        send_sample(mk(32'h0000_0050, 1'b1, 2'b10, 2'b10, 2'b10, 1'b0));
        ms_clock  = 32'h0000_0050;
        btn_level = 2'b10;

        db_plan[0] = 16'd0;                       win_plan[0] = 16'd0;
        db_plan[1] = 16'hFFFF;                    win_plan[1] = 16'hFFFF;
        db_plan[2] = 16'd3;                       win_plan[2] = 16'd10;
        db_plan[3] = 16'($urandom_range(0, 300)); win_plan[3] = 16'($urandom_range(0, 1000));
        db_plan[4] = 16'hFFFF;                    win_plan[4] = 16'd0;
        db_plan[5] = 16'd0;                       win_plan[5] = 16'hFFFF;
        db_plan[6] = 16'($urandom());             win_plan[6] = 16'($urandom());
        db_plan[7] = DEBOUNCE_TIME_RST;           win_plan[7] = EVENT_WINDOW_RST;

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            program_regs(db_plan[ph], win_plan[ph], ph == 3);
            if (ph == NUM_PHASES - 1)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            run_random(PHASE_SAMPLES, db_plan[ph], win_plan[ph]);
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Sent %0d samples across %0d register settings, including the extremes.",
                 n_sent, NUM_PHASES + 1);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
